// ===== rtl/srt_pkg.sv =====
package srt_pkg;

	localparam int unsigned DEPTH = 32;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned KEY_W = 160;
	localparam int unsigned MON_W = 7;
	localparam int unsigned REC_W = KEY_W + 64 + 56 + 27 + MON_W;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [REC_W-1:0] rec_t;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LIST   = 2'd1,
		OP_DELETE = 2'd2,
		OP_FIND   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_RECORD   = 3'd0,
		ST_INSERTED = 3'd1,
		ST_FULL     = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_DELETED  = 3'd4,
		ST_NOTFOUND = 3'd5,
		ST_NOMATCH  = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_INS_RD,
		S_INS_CMP,
		S_INS_PUT,
		S_DEL_RD,
		S_DEL_CMP,
		S_SCAN_RD,
		S_SCAN_EMIT,
		S_STATUS
	} state_t;

	// record layout: key, phone high, phone low, birth, month of birth
	function automatic key_t rec_key(input rec_t r);
		return r[REC_W-1 -: KEY_W];
	endfunction

	function automatic logic [26:0] rec_birth(input rec_t r);
		return r[MON_W +: 27];
	endfunction

	function automatic logic [MON_W-1:0] rec_month(input rec_t r);
		return r[MON_W-1:0];
	endfunction

endpackage

// ===== rtl/srt_ram.sv =====
module srt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/srt_month.sv =====
// Month of a birth value, (b / 100) % 100, by two reciprocal multiplications.
// The first quotient is registered, then the second quotient with a copy of the first.
module srt_month (
	input  logic        clk,
	input  logic [26:0] birth,
	output logic [6:0]  month
);

	logic [54:0] prod0;
	logic [42:0] prod1;
	logic [20:0] q1_s1;
	logic [20:0] q1_s2;
	logic [14:0] q2_s2;

	// ceil(2^34 / 100) and ceil(2^28 / 100) give exact quotients over the whole input range
	always_comb begin
		prod0 = 55'(birth) * 55'd171798692;
		prod1 = 43'(q1_s1) * 43'd2684355;
		month = 7'(q1_s2 - 21'(q2_s2) * 21'd100);
	end

	always_ff @(posedge clk) begin
		q1_s1 <= prod0[54:34];
		q1_s2 <= q1_s1;
		q2_s2 <= prod1[42:28];
	end

endmodule

// ===== rtl/sorted_record_table.sv =====
// Channel | Direction | Handshake             | Payload
// in      | input     | valid / stall         | op, name_*, phone_*, birth_value, query_month
// out     | output    | out_valid / out_stall | status, entry_total, out_*, last
// An insert compares entries from the end of the table down, a delete walks every
// stored entry, and list and find read every stored entry; an insert into a full
// table or a delete, list or find on an empty one goes straight to its status. Each entry is one
// memory read followed by a compare, a write back or a result.
// Reset clears the count and control; the memory is not cleared.
// A result waiting on out_stall holds the walk; stall stays high from accept
// until the final result is loaded into the output register.
module sorted_record_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid,
	output logic          stall,
	input  logic [1:0]    op,
	input  logic [63:0]   name_high,
	input  logic [63:0]   name_middle,
	input  logic [31:0]   name_low,
	input  logic [63:0]   phone_high,
	input  logic [55:0]   phone_low,
	input  logic [26:0]   birth_value,
	input  logic [6:0]    query_month,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [2:0]    status,
	output logic [6:0]    entry_total,
	output logic [63:0]   out_name_high,
	output logic [63:0]   out_name_middle,
	output logic [31:0]   out_name_low,
	output logic [63:0]   out_phone_high,
	output logic [55:0]   out_phone_low,
	output logic [26:0]   out_birth,
	output logic          last
);

	localparam int unsigned AW = srt_pkg::AW;
	localparam int unsigned CW = srt_pkg::CW;

	srt_pkg::state_t  state_q, state_d;
	srt_pkg::op_t     op_q;
	srt_pkg::status_t st_q;
	srt_pkg::rec_t    new_q;
	logic [6:0]       qmonth_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    idx_inc, idx_dec;
	logic             found_q;
	srt_pkg::rec_t    pend_q;
	logic             pend_v_q;

	logic             we;
	logic [AW-1:0]    waddr, raddr;
	srt_pkg::rec_t    wdata, rdata;
	logic [6:0]       new_month;

	logic             ovalid_q;
	srt_pkg::status_t ostatus_q;
	logic [6:0]       ototal_q;
	srt_pkg::rec_t    orec_q;
	logic             olast_q;

	logic             out_free, idx_end, key_gt, key_eq, ins_shift;
	logic             scan_hit, scan_adv, load_rec, load_status;

	srt_ram #(.WIDTH(srt_pkg::REC_W), .DEPTH(srt_pkg::DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	srt_month u_month (.clk(clk), .birth(srt_pkg::rec_birth(new_q)), .month(new_month));

	assign out_free = !ovalid_q || !out_stall;
	assign stall = (state_q != srt_pkg::S_IDLE);

	assign idx_inc = idx_q + CW'(1);
	assign idx_dec = idx_q - CW'(1);
	assign idx_end = (idx_inc >= count_q);

	assign key_gt = srt_pkg::rec_key(rdata) > srt_pkg::rec_key(new_q);
	assign key_eq = srt_pkg::rec_key(rdata) == srt_pkg::rec_key(new_q);
	assign ins_shift = (idx_q != '0) && key_gt;

	// a hit goes to the pending register; the previous one leaves only when
	// the next hit or the end of the walk shows whether it is the final result
	assign scan_hit = (op_q == srt_pkg::OP_LIST) || (srt_pkg::rec_month(rdata) == qmonth_q);
	assign scan_adv = (state_q == srt_pkg::S_SCAN_EMIT) && (!scan_hit || !pend_v_q || out_free);
	assign load_rec = (scan_adv && scan_hit && pend_v_q)
		|| ((state_q == srt_pkg::S_STATUS) && out_free && pend_v_q);
	assign load_status = (state_q == srt_pkg::S_STATUS) && out_free && !pend_v_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			srt_pkg::S_IDLE: begin
				if (valid) state_d = srt_pkg::S_DISPATCH;
			end
			srt_pkg::S_DISPATCH: begin
				case (op_q)
					srt_pkg::OP_INSERT: state_d = (count_q >= CW'(srt_pkg::DEPTH))
						? srt_pkg::S_STATUS : srt_pkg::S_INS_RD;
					srt_pkg::OP_DELETE: state_d = (count_q == '0) ? srt_pkg::S_STATUS
						: srt_pkg::S_DEL_RD;
					default: state_d = (count_q == '0) ? srt_pkg::S_STATUS
						: srt_pkg::S_SCAN_RD;
				endcase
			end
			srt_pkg::S_INS_RD:  state_d = srt_pkg::S_INS_CMP;
			srt_pkg::S_INS_CMP: begin
				if (ins_shift && idx_q > CW'(1)) state_d = srt_pkg::S_INS_RD;
				else state_d = srt_pkg::S_INS_PUT;
			end
			srt_pkg::S_INS_PUT: state_d = srt_pkg::S_STATUS;
			srt_pkg::S_DEL_RD:  state_d = srt_pkg::S_DEL_CMP;
			srt_pkg::S_DEL_CMP: state_d = idx_end ? srt_pkg::S_STATUS : srt_pkg::S_DEL_RD;
			srt_pkg::S_SCAN_RD: state_d = srt_pkg::S_SCAN_EMIT;
			srt_pkg::S_SCAN_EMIT: begin
				if (scan_adv) state_d = idx_end ? srt_pkg::S_STATUS : srt_pkg::S_SCAN_RD;
			end
			srt_pkg::S_STATUS: if (out_free) state_d = srt_pkg::S_IDLE;
			default: state_d = srt_pkg::S_IDLE;
		endcase
	end

	// memory access
	always_comb begin
		we = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rdata;
		raddr = idx_q[AW-1:0];
		case (state_q)
			srt_pkg::S_INS_RD: raddr = idx_dec[AW-1:0];
			srt_pkg::S_INS_CMP: begin
				if (ins_shift) we = 1'b1;
			end
			srt_pkg::S_INS_PUT: begin
				we = 1'b1;
				wdata = {new_q[srt_pkg::REC_W-1:srt_pkg::MON_W], new_month};
			end
			srt_pkg::S_DEL_CMP: begin
				// move each entry after the match down by one
				if (found_q) begin
					we = 1'b1;
					waddr = idx_dec[AW-1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srt_pkg::S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
			pend_v_q <= 1'b0;
			st_q <= srt_pkg::ST_RECORD;
			op_q <= srt_pkg::OP_INSERT;
		end else begin
			state_q <= state_d;
			case (state_q)
				srt_pkg::S_IDLE: begin
					if (valid) begin
						op_q <= srt_pkg::op_t'(op);
						found_q <= 1'b0;
						pend_v_q <= 1'b0;
					end
				end
				srt_pkg::S_DISPATCH: begin
					case (op_q)
						srt_pkg::OP_INSERT: begin
							idx_q <= count_q;
							st_q <= (count_q >= CW'(srt_pkg::DEPTH)) ? srt_pkg::ST_FULL
								: srt_pkg::ST_INSERTED;
						end
						srt_pkg::OP_DELETE: begin
							idx_q <= '0;
							st_q <= (count_q == '0) ? srt_pkg::ST_EMPTY
								: srt_pkg::ST_NOTFOUND;
						end
						srt_pkg::OP_LIST: begin
							idx_q <= '0;
							st_q <= srt_pkg::ST_EMPTY;
						end
						default: begin
							idx_q <= '0;
							st_q <= srt_pkg::ST_NOMATCH;
						end
					endcase
				end
				srt_pkg::S_INS_CMP: begin
					if (ins_shift) idx_q <= idx_dec;
				end
				srt_pkg::S_INS_PUT: count_q <= count_q + CW'(1);
				srt_pkg::S_DEL_CMP: begin
					if (found_q || key_eq) begin
						found_q <= 1'b1;
						st_q <= srt_pkg::ST_DELETED;
						if (idx_end) count_q <= count_q - CW'(1);
					end
					idx_q <= idx_inc;
				end
				srt_pkg::S_SCAN_EMIT: begin
					if (scan_adv) begin
						idx_q <= idx_inc;
						if (scan_hit) pend_v_q <= 1'b1;
					end
				end
				srt_pkg::S_STATUS: begin
					if (out_free) pend_v_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			ostatus_q <= srt_pkg::ST_RECORD;
			ototal_q <= '0;
			olast_q <= 1'b0;
		end else begin
			ovalid_q <= load_rec || load_status || (ovalid_q && out_stall);
			if (load_rec) begin
				ostatus_q <= srt_pkg::ST_RECORD;
				ototal_q <= 7'(count_q);
				olast_q <= (state_q == srt_pkg::S_STATUS);
			end else if (load_status) begin
				ostatus_q <= st_q;
				ototal_q <= 7'(count_q);
				olast_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == srt_pkg::S_IDLE && valid) begin
			new_q <= {name_high, name_middle, name_low, phone_high, phone_low, birth_value,
				7'd0};
			qmonth_q <= query_month;
		end
		if (scan_adv && scan_hit) pend_q <= rdata;
		if (load_rec) orec_q <= pend_q;
		else if (load_status) orec_q <= '0;
	end

	assign out_valid       = ovalid_q;
	assign status          = ostatus_q;
	assign entry_total     = ototal_q;
	assign last            = olast_q;
	assign out_name_high   = orec_q[srt_pkg::REC_W-1 -: 64];
	assign out_name_middle = orec_q[srt_pkg::REC_W-65 -: 64];
	assign out_name_low    = orec_q[srt_pkg::REC_W-129 -: 32];
	assign out_phone_high  = orec_q[srt_pkg::REC_W-161 -: 64];
	assign out_phone_low   = orec_q[srt_pkg::REC_W-225 -: 56];
	assign out_birth       = srt_pkg::rec_birth(orec_q);

endmodule

// ===== rtl/srt_checker.sv =====
module srt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] status,
	input logic [6:0] entry_total,
	input logic       last
);

	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_total <= 7'(srt_pkg::DEPTH))
		else $error("entry total above depth");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != srt_pkg::ST_RECORD) |-> last)
		else $error("status result not last");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(last)))
		else $error("stalled result changed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !stall) |=> stall)
		else $error("accepted item without going busy");

endmodule

bind sorted_record_table srt_checker u_srt_checker (
	.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall), .out_valid(out_valid),
	.out_stall(out_stall), .status(status), .entry_total(entry_total), .last(last)
);

// ===== bench/tb_sorted_record_table.sv =====
`timescale 1ns / 1ps

module tb_sorted_record_table;

	localparam int RAND_ITEMS = 314;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [2:0]  status;
		logic [6:0]  entry_total;
		logic [63:0] nh;
		logic [63:0] nm;
		logic [31:0] nl;
		logic [63:0] ph;
		logic [55:0] pl;
		logic [26:0] birth;
		logic        last;
	} result_t;

	typedef struct {
		logic [63:0] nh;
		logic [63:0] nm;
		logic [31:0] nl;
		logic [63:0] ph;
		logic [55:0] pl;
		logic [26:0] birth;
	} entry_t;

	typedef struct {
		srt_pkg::op_t     op;
		logic [63:0]      nh;
		logic [63:0]      nm;
		logic [31:0]      nl;
		logic [63:0]      ph;
		logic [55:0]      pl;
		logic [26:0]      birth;
		logic [6:0]       month;
		bit               has_status;
		srt_pkg::status_t want_status;
		logic [6:0]       want_total;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic valid = 0;
	logic stall;
	logic [1:0] op = 0;
	logic [63:0] name_high = 0;
	logic [63:0] name_middle = 0;
	logic [31:0] name_low = 0;
	logic [63:0] phone_high = 0;
	logic [55:0] phone_low = 0;
	logic [26:0] birth_value = 0;
	logic [6:0] query_month = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [2:0] status;
	logic [6:0] entry_total;
	logic [63:0] out_name_high, out_name_middle, out_phone_high;
	logic [31:0] out_name_low;
	logic [55:0] out_phone_low;
	logic [26:0] out_birth;
	logic last;

	sorted_record_table uut (.*);

	always #2 clk = ~clk;

	entry_t  table_model[$];
	result_t expected_results[$];
	int errors = 0;
	int results_seen = 0;
	int items_sent = 0;
	int cycles = 0;
	bit hold_long = 0;
	int full_hits = 0, find_hits = 0;
	row_t dir_rows[$];

	function automatic result_t status_result(srt_pkg::status_t st);
		result_t r;
		r = '{default: '0};
		r.status = st;
		r.entry_total = 7'(table_model.size());
		r.last = 1;
		return r;
	endfunction

	function automatic result_t record_result(entry_t e);
		result_t r;
		r.status = srt_pkg::ST_RECORD;
		r.entry_total = 7'(table_model.size());
		r.nh = e.nh; r.nm = e.nm; r.nl = e.nl;
		r.ph = e.ph; r.pl = e.pl; r.birth = e.birth;
		r.last = 0;
		return r;
	endfunction

	// apply one item to the model table and queue the results it causes
	task automatic predict_table(input row_t it);
		logic [159:0] key, k2;
		entry_t e;
		int pos, n;
		key = {it.nh, it.nm, it.nl};
		e = '{it.nh, it.nm, it.nl, it.ph, it.pl, it.birth};
		n = 0;
		case (it.op)
			srt_pkg::OP_INSERT: begin
				if (table_model.size() >= srt_pkg::DEPTH) begin
					full_hits++;
					expected_results.push_back(status_result(srt_pkg::ST_FULL));
				end else begin
					pos = table_model.size();
					while (pos > 0) begin
						k2 = {table_model[pos-1].nh, table_model[pos-1].nm,
							table_model[pos-1].nl};
						if (k2 > key) pos--;
						else break;
					end
					table_model.insert(pos, e);
					expected_results.push_back(status_result(srt_pkg::ST_INSERTED));
				end
			end
			srt_pkg::OP_DELETE: begin
				if (table_model.size() == 0) begin
					expected_results.push_back(status_result(srt_pkg::ST_EMPTY));
				end else begin
					pos = -1;
					foreach (table_model[k])
						if (pos < 0 && {table_model[k].nh, table_model[k].nm,
							table_model[k].nl} == key) pos = k;
					if (pos < 0)
						expected_results.push_back(status_result(srt_pkg::ST_NOTFOUND));
					else begin
						table_model.delete(pos);
						expected_results.push_back(status_result(srt_pkg::ST_DELETED));
					end
				end
			end
			srt_pkg::OP_LIST: begin
				if (table_model.size() == 0)
					expected_results.push_back(status_result(srt_pkg::ST_EMPTY));
				else begin
					foreach (table_model[k])
						expected_results.push_back(record_result(table_model[k]));
					expected_results[$].last = 1;
				end
			end
			default: begin
				foreach (table_model[k])
					if ((table_model[k].birth / 100) % 100 == it.month) begin
						expected_results.push_back(record_result(table_model[k]));
						n++;
					end
				if (n == 0) expected_results.push_back(status_result(srt_pkg::ST_NOMATCH));
				else begin
					find_hits++;
					expected_results[$].last = 1;
				end
			end
		endcase
	endtask

	// keep names in a small pool so deletes and duplicates hit often
	function automatic row_t random_row();
		row_t r;
		int sel;
		r.op = srt_pkg::op_t'($urandom_range(0, 3));
		if ($urandom_range(0, 9) < 4) r.op = srt_pkg::OP_INSERT;
		sel = $urandom_range(0, 15);
		if (sel < 12) begin
			r.nh = {8'h41 + sel[7:0], 56'h0};
			r.nm = (sel % 3 == 0) ? 64'h1 : 64'h0;
			r.nl = 0;
		end else begin
			r.nh = {$urandom, $urandom};
			r.nm = {$urandom, $urandom};
			r.nl = $urandom;
		end
		r.ph = {$urandom, $urandom};
		r.pl = 56'({$urandom, $urandom});
		r.birth = ($urandom_range(0, 3) == 0) ? 27'($urandom) :
			27'(19000000 + $urandom_range(0, 99) * 10000 + $urandom_range(1, 12) * 100
			+ $urandom_range(1, 28));
		r.month = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 12));
		r.has_status = 0;
		r.want_status = srt_pkg::ST_RECORD;
		r.want_total = 0;
		return r;
	endfunction

	function automatic row_t drow(srt_pkg::op_t o, logic [63:0] nh, logic [63:0] nm,
			logic [31:0] nl, logic [26:0] b, logic [6:0] m, bit hs,
			srt_pkg::status_t st, logic [6:0] tot);
		row_t r;
		r.op = o; r.nh = nh; r.nm = nm; r.nl = nl;
		r.ph = {nh[31:0], nm[31:0]}; r.pl = {nl, 24'h5a5a5a};
		r.birth = b; r.month = m;
		r.has_status = hs; r.want_status = st; r.want_total = tot;
		return r;
	endfunction

	task automatic send_item(input row_t it);
		result_t r;
		valid <= 1;
		op <= it.op;
		name_high <= it.nh; name_middle <= it.nm; name_low <= it.nl;
		phone_high <= it.ph; phone_low <= it.pl;
		birth_value <= it.birth; query_month <= it.month;
		do @(posedge clk); while (stall);
		predict_table(it);
		if (it.has_status) begin
			r = expected_results[$];
			if (r.status != it.want_status || r.entry_total != it.want_total) begin
				$display("%0t directed row: expected status %0d total %0d, actual %0d %0d",
					$time, it.want_status, it.want_total, r.status, r.entry_total);
				errors++;
			end
		end
		items_sent++;
	endtask

	task automatic idle_gap();
		valid <= 0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	initial begin
		row_t it;
		int burst;
		dir_rows.push_back(drow(srt_pkg::OP_LIST, 0, 0, 0, 0, 0, 1, srt_pkg::ST_EMPTY, 0));
		dir_rows.push_back(drow(srt_pkg::OP_DELETE, 0, 0, 0, 0, 0, 1, srt_pkg::ST_EMPTY, 0));
		dir_rows.push_back(drow(srt_pkg::OP_FIND, 0, 0, 0, 0, 5, 1, srt_pkg::ST_NOMATCH, 0));
		dir_rows.push_back(drow(srt_pkg::OP_INSERT, '1, '1, '1, '1, 0, 1,
			srt_pkg::ST_INSERTED, 1));
		dir_rows.push_back(drow(srt_pkg::OP_INSERT, 0, 0, 0, 0, 0, 1,
			srt_pkg::ST_INSERTED, 2));
		dir_rows.push_back(drow(srt_pkg::OP_INSERT, 64'h4100_0000_0000_0000, 0, 0,
			19991231, 12, 1, srt_pkg::ST_INSERTED, 3));
		// bytes after the terminator still count in the key
		dir_rows.push_back(drow(srt_pkg::OP_INSERT, 64'h4100_0000_0000_0000, 0, 1,
			20000115, 1, 1, srt_pkg::ST_INSERTED, 4));
		dir_rows.push_back(drow(srt_pkg::OP_INSERT, 64'h4100_0000_0000_0000, 0, 0,
			99999999, 99, 1, srt_pkg::ST_INSERTED, 5));
		dir_rows.push_back(drow(srt_pkg::OP_LIST, 0, 0, 0, 0, 0, 0, srt_pkg::ST_RECORD, 0));
		dir_rows.push_back(drow(srt_pkg::OP_FIND, 0, 0, 0, 0, 12, 0, srt_pkg::ST_RECORD, 0));
		dir_rows.push_back(drow(srt_pkg::OP_FIND, 0, 0, 0, 0, 99, 0, srt_pkg::ST_RECORD, 0));
		dir_rows.push_back(drow(srt_pkg::OP_FIND, 0, 0, 0, 0, 127, 1,
			srt_pkg::ST_NOMATCH, 5));
		dir_rows.push_back(drow(srt_pkg::OP_FIND, 0, 0, 0, 0, 0, 0, srt_pkg::ST_RECORD, 0));
		dir_rows.push_back(drow(srt_pkg::OP_DELETE, 64'h4100_0000_0000_0000, 0, 2, 0, 0,
			1, srt_pkg::ST_NOTFOUND, 5));
		dir_rows.push_back(drow(srt_pkg::OP_DELETE, 64'h4100_0000_0000_0000, 0, 0, 0, 0,
			1, srt_pkg::ST_DELETED, 4));
		dir_rows.push_back(drow(srt_pkg::OP_DELETE, '1, '1, '1, 0, 0, 1,
			srt_pkg::ST_DELETED, 3));
		dir_rows.push_back(drow(srt_pkg::OP_LIST, 0, 0, 0, 0, 0, 0, srt_pkg::ST_RECORD, 0));

		repeat (5) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i]);
			if ($urandom_range(0, 2) == 0) idle_gap();
		end
		// fill to the top to reach the full case
		for (int i = 0; i < 32; i++) begin
			it = random_row();
			it.op = srt_pkg::OP_INSERT;
			send_item(it);
		end
		it = random_row();
		it.op = srt_pkg::OP_LIST;
		send_item(it);
		// long receiver hold while items keep coming
		hold_long = 1;
		for (int i = 0; i < 6; i++) begin
			it = random_row();
			send_item(it);
		end
		hold_long = 0;
		while (items_sent < dir_rows.size() + 39 + RAND_ITEMS) begin
			burst = $urandom_range(0, 12);
			for (int i = 0; i < burst; i++) begin
				it = random_row();
				send_item(it);
			end
			idle_gap();
		end
		valid <= 0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("%0d items sent, %0d results checked, %0d full inserts, %0d finds hit",
			items_sent, results_seen, full_hits, find_hits);
		if (errors == 0 && expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// receiver stall pattern plus one long hold
	initial begin
		int phase;
		phase = 0;
		forever begin
			@(posedge clk);
			if (hold_long) begin
				out_stall <= 1;
				repeat (300) @(posedge clk);
				out_stall <= 0;
				wait (!hold_long);
			end else begin
				phase++;
				if ((phase / 64) % 3 == 2) out_stall <= 0;
				else out_stall <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	always @(posedge clk) begin
		result_t w;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result: status %0d", $time, status);
				errors++;
			end else begin
				w = expected_results.pop_front();
				if ({status, entry_total, out_name_high, out_name_middle, out_name_low,
					out_phone_high, out_phone_low, out_birth, last} !==
					{w.status, w.entry_total, w.nh, w.nm, w.nl, w.ph, w.pl,
					w.birth, w.last}) begin
					$display("%0t mismatch: expected st %0d tot %0d name %h%h%h ph %h%h b %0d l %0b",
						$time, w.status, w.entry_total, w.nh, w.nm, w.nl, w.ph, w.pl,
						w.birth, w.last);
					$display("%0t          actual st %0d tot %0d name %h%h%h ph %h%h b %0d l %0b",
						$time, status, entry_total, out_name_high, out_name_middle,
						out_name_low, out_phone_high, out_phone_low, out_birth, last);
					errors++;
				end
			end
		end
	end

endmodule
